@@ hdl/lfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lfsp_pkg
// Widths, register indexes and state codes shared by the lattice site placer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsp_pkg;

    // field widths of the channels and the configuration port
    localparam int GRID_W    = 5;
    localparam int PLACE_W   = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COMP_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int SITE_W    = 4;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PLACEMENTS = 1'b1;

    // register reset values and side limits
    localparam int                 MIN_SIDE             = 3;
    localparam int                 RESET_GRID_SIZE      = 4;
    localparam logic [PLACE_W-1:0] RESET_MAX_PLACEMENTS = 13'd4096;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

endpackage

`default_nettype wire

@@ hdl/lfsp_in_if.sv @@
// ----------------------------------------------------------------------------
// lfsp_in_if
// Request channel: one beat asks for one site placement.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfsp_in_if;
    import lfsp_pkg::*;

    logic              valid;
    logic              ready;
    logic              start_new;
    logic [COMP_W-1:0] place_component;
    logic [FRAC_W-1:0] random_fraction;

    modport source (
        output valid, start_new, place_component, random_fraction,
        input  ready
    );

    modport sink (
        input  valid, start_new, place_component, random_fraction,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lfsp_out_if.sv @@
// ----------------------------------------------------------------------------
// lfsp_out_if
// Result channel: one beat reports one placed site or a failure.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfsp_out_if;
    import lfsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [SITE_W-1:0]  site_x;
    logic [SITE_W-1:0]  site_y;
    logic [SITE_W-1:0]  site_z;
    logic [INDEX_W-1:0] site_index;
    logic [COMP_W-1:0]  placed_component;
    logic [COUNT_W-1:0] candidate_count;
    logic               failed;

    modport source (
        output valid, site_x, site_y, site_z, site_index, placed_component,
               candidate_count, failed,
        input  ready
    );

    modport sink (
        input  valid, site_x, site_y, site_z, site_index, placed_component,
               candidate_count, failed,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lfsp_grid_mem.sv @@
// ----------------------------------------------------------------------------
// lfsp_grid_mem
// Minimum squared distance store: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsp_grid_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/lfsp_dist.sv @@
// ----------------------------------------------------------------------------
// lfsp_dist
// Periodic squared distance from a scanned point to the chosen site.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsp_dist #(
    parameter int SW = 5,
    parameter int CW = 4,
    parameter int DW = 13
) (
    input  wire logic          i_clk,
    input  wire logic [SW-1:0] i_side,
    input  wire logic [CW-1:0] i_x,
    input  wire logic [CW-1:0] i_y,
    input  wire logic [CW-1:0] i_z,
    input  wire logic [CW-1:0] i_cx,
    input  wire logic [CW-1:0] i_cy,
    input  wire logic [CW-1:0] i_cz,
    output logic      [DW-1:0] o_d2
);
    localparam int SQW = 2 * CW + 2;

    // minimum image along one axis
    function automatic logic [CW-1:0] axis_gap(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b,
        input logic [SW-1:0] n
    );
        logic [CW-1:0] d;
        d = (a > b) ? a - b : b - a;
        if ({d, 1'b0} > (CW + 1)'(n)) begin
            d = CW'(n - SW'(d));
        end
        return d;
    endfunction

    logic [CW-1:0]  gx, gy, gz;
    logic [SQW-1:0] sum;
    logic [DW-1:0]  r_d2;

    always_comb begin
        gx  = axis_gap(i_x, i_cx, i_side);
        gy  = axis_gap(i_y, i_cy, i_side);
        gz  = axis_gap(i_z, i_cz, i_side);
        sum = SQW'(gx) * SQW'(gx) + SQW'(gy) * SQW'(gy) + SQW'(gz) * SQW'(gz);
    end

    always_ff @(posedge i_clk) begin
        r_d2 <= DW'(sum);
    end

    assign o_d2 = r_d2;

endmodule

`default_nettype wire

@@ hdl/lattice_farthest_site_placer_unit.sv @@
// ----------------------------------------------------------------------------
// lattice_farthest_site_placer_unit
// Farthest point placement on a periodic cubic lattice, one site per request.
// ----------------------------------------------------------------------------
//  channel    dir  beat contents
//  i_item     in   start_new, place_component, random_fraction
//  o_result   out  site_x/y/z, site_index, placed_component,
//                  candidate_count, failed
//  i_cfg_*    in   register index and write data, no handshake
//
//  A placement returns its result after the selection scan over the lattice;
//  the update scan then runs over it again and the unit returns to idle before
//  it takes the next beat, bound by the single read port. A failed request
//  returns in the cycle after its beat is accepted.
//  The update scan also gathers the largest minimum and its count for the
//  next request, and runs while the result waits in the output register.
//  Reset and a grid_size write mark the memory as all-sentinel with one flag
//  (no clearing pass); a grid_size write holds off requests until the square and cube of the side have settled.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_farthest_site_placer_unit #(
    parameter int MAX_SIDE = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lfsp_in_if.sink                              i_item,
    lfsp_out_if.source                           o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lfsp_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import lfsp_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int SQW   = 2 * SW;
    localparam int PW    = FRAC_W + DW;

    localparam int RST_SIDE = (RESET_GRID_SIZE > MAX_SIDE) ? MAX_SIDE : RESET_GRID_SIZE;
    localparam int RST_SQ   = RST_SIDE * RST_SIDE;
    localparam int RST_SENT = RST_SQ * RST_SIDE;

    // control
    t_state             r_state, n_state;
    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_settle, n_settle;
    logic               r_pend, n_pend;
    logic [PLACE_W-1:0] r_placed, n_placed;
    logic [PLACE_W-1:0] r_max, n_max;
    logic [SW-1:0]      r_side, n_side;
    logic [SQW-1:0]     r_sq;
    logic [DW-1:0]      r_sent;
    logic               r_found, n_found;
    logic [DW-1:0]      r_seen, n_seen;

    // scan pipeline
    logic               r_issue, n_issue;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_x, n_x, r_y, n_y, r_z, n_z;
    logic               r_b_vld, r_b_last;
    logic [AW-1:0]      r_b_pos;
    logic [CW-1:0]      r_b_x, r_b_y, r_b_z;

    // per request data
    logic [DW-1:0]      r_best, r_count;
    logic [DW-1:0]      r_sel_best, r_cand, r_pick;
    logic [COMP_W-1:0]  r_comp;
    logic [CW-1:0]      r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic [AW-1:0]      r_cpos, n_cpos;
    logic [DW-1:0]      r_acc_best, r_acc_cnt, n_acc_best, n_acc_cnt;

    // result register
    logic [SITE_W-1:0]  r_o_x, r_o_y, r_o_z;
    logic [INDEX_W-1:0] r_o_index;
    logic [COMP_W-1:0]  r_o_comp;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_failed;

    logic               accept, in_ready, eff_clear, limit_hit;
    logic [DW-1:0]      eff_count, eff_best;
    logic [PLACE_W-1:0] eff_placed;
    logic [PW-1:0]      prod;
    logic [SW-1:0]      side_m1;
    logic               x_last, y_last, z_last, scan_last;
    logic               sel_done, upd_done, scan_go, grid_wr;
    logic [DW-1:0]      rd_data, cell_val, d2, upd_val;
    logic               sel_match, sel_hit;
    logic [GRID_W-1:0]  cfg_grid;

    lfsp_grid_mem #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (DW)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPD && r_b_vld),
        .i_waddr (r_b_pos),
        .i_wdata (upd_val),
        .i_re    (r_issue),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    lfsp_dist #(
        .SW (SW),
        .CW (CW),
        .DW (DW)
    ) u_dist (
        .i_clk  (i_clk),
        .i_side (r_side),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_z    (r_z),
        .i_cx   (r_cx),
        .i_cy   (r_cy),
        .i_cz   (r_cz),
        .o_d2   (d2)
    );

    // request side
    always_comb begin
        in_ready   = (r_state == ST_IDLE) && (r_settle == 2'd0) &&
                     (!r_ovalid || o_result.ready);
        accept     = i_item.valid && in_ready;
        eff_clear  = i_item.start_new || r_pend;
        eff_count  = eff_clear ? r_sent : r_count;
        eff_best   = eff_clear ? r_sent : r_best;
        eff_placed = i_item.start_new ? '0 : r_placed;
        limit_hit  = eff_placed >= r_max;
        prod       = PW'(i_item.random_fraction) * PW'(eff_count);
        grid_wr    = i_cfg_we && (i_cfg_idx == CFG_GRID_SIZE);
        cfg_grid   = i_cfg_wdata[GRID_W-1:0];
    end

    // scan position and memory side
    always_comb begin
        side_m1   = r_side - SW'(1);
        x_last    = SW'(r_x) == side_m1;
        y_last    = SW'(r_y) == side_m1;
        z_last    = SW'(r_z) == side_m1;
        scan_last = x_last && y_last && z_last;
        sel_done  = (r_state == ST_SEL) && r_b_vld && r_b_last;
        upd_done  = (r_state == ST_UPD) && r_b_vld && r_b_last;
        scan_go   = (accept && !limit_hit) || sel_done;
        // an untouched memory after a clear reads as the sentinel
        cell_val  = r_pend ? r_sent : rd_data;
        upd_val   = (d2 < cell_val) ? d2 : cell_val;
        sel_match = cell_val == r_sel_best;
        sel_hit   = (r_state == ST_SEL) && r_b_vld && sel_match && !r_found &&
                    (r_seen == r_pick);
    end

    always_comb begin
        n_cx   = sel_hit ? r_b_x : r_cx;
        n_cy   = sel_hit ? r_b_y : r_cy;
        n_cz   = sel_hit ? r_b_z : r_cz;
        n_cpos = sel_hit ? r_b_pos : r_cpos;

        if (r_b_pos == '0 || upd_val > r_acc_best) begin
            n_acc_best = upd_val;
            n_acc_cnt  = DW'(1);
        end else if (upd_val == r_acc_best) begin
            n_acc_best = r_acc_best;
            n_acc_cnt  = r_acc_cnt + DW'(1);
        end else begin
            n_acc_best = r_acc_best;
            n_acc_cnt  = r_acc_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !limit_hit) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                if (sel_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (upd_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_issue = r_issue;
        n_pos   = r_pos;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        if (scan_go) begin
            n_issue = 1'b1;
            n_pos   = '0;
            n_x     = '0;
            n_y     = '0;
            n_z     = '0;
        end else if (r_issue) begin
            n_pos = r_pos + AW'(1);
            if (z_last) begin
                n_z = '0;
                if (y_last) begin
                    n_y = '0;
                    n_x = r_x + CW'(1);
                end else begin
                    n_y = r_y + CW'(1);
                end
            end else begin
                n_z = r_z + CW'(1);
            end
            if (scan_last) begin
                n_issue = 1'b0;
            end
        end

        n_ovalid = r_ovalid && !o_result.ready;
        if ((accept && limit_hit) || sel_done) begin
            n_ovalid = 1'b1;
        end

        n_found = r_found;
        n_seen  = r_seen;
        if (accept) begin
            n_found = 1'b0;
            n_seen  = '0;
        end else if (r_state == ST_SEL && r_b_vld && sel_match && !r_found) begin
            if (r_seen == r_pick) begin
                n_found = 1'b1;
            end else begin
                n_seen = r_seen + DW'(1);
            end
        end

        n_pend   = r_pend;
        n_placed = r_placed;
        if (accept && i_item.start_new) begin
            n_pend   = 1'b1;
            n_placed = '0;
        end
        if (upd_done) begin
            n_pend   = 1'b0;
            n_placed = r_placed + PLACE_W'(1);
        end

        n_side   = r_side;
        n_max    = r_max;
        n_settle = (r_settle != 2'd0) ? r_settle - 2'd1 : r_settle;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_SIZE: begin
                    if (cfg_grid < GRID_W'(MIN_SIDE)) begin
                        n_side = SW'(MIN_SIDE);
                    end else if ((GRID_W + 1)'(cfg_grid) > (GRID_W + 1)'(MAX_SIDE)) begin
                        n_side = SW'(MAX_SIDE);
                    end else begin
                        n_side = SW'(cfg_grid);
                    end
                end
                CFG_MAX_PLACEMENTS: n_max = i_cfg_wdata[PLACE_W-1:0];
                default: n_max = r_max;
            endcase
        end
        if (grid_wr) begin
            // square and cube follow the side through r_sq, then r_sent
            n_settle = 2'd2;
            n_pend   = 1'b1;
            n_placed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_settle <= 2'd0;
            r_pend   <= 1'b1;
            r_placed <= '0;
            r_max    <= RESET_MAX_PLACEMENTS;
            r_side   <= SW'(RST_SIDE);
            r_sq     <= SQW'(RST_SQ);
            r_sent   <= DW'(RST_SENT);
            r_found  <= 1'b0;
            r_seen   <= '0;
            r_issue  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_b_last <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_settle <= n_settle;
            r_pend   <= n_pend;
            r_placed <= n_placed;
            r_max    <= n_max;
            r_side   <= n_side;
            r_sq     <= SQW'(r_side) * SQW'(r_side);
            r_sent   <= DW'(r_sq) * DW'(r_side);
            r_found  <= n_found;
            r_seen   <= n_seen;
            r_issue  <= n_issue;
            r_b_vld  <= r_issue;
            r_b_last <= r_issue && scan_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_b_pos <= r_pos;
        r_b_x   <= r_x;
        r_b_y   <= r_y;
        r_b_z   <= r_z;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_cpos  <= n_cpos;

        if (accept) begin
            r_sel_best <= eff_best;
            r_cand     <= eff_count;
            r_pick     <= prod[PW-1:FRAC_W];
            r_comp     <= i_item.place_component;
        end

        if (r_state == ST_UPD && r_b_vld) begin
            r_acc_best <= n_acc_best;
            r_acc_cnt  <= n_acc_cnt;
        end
        if (upd_done) begin
            r_best  <= n_acc_best;
            r_count <= n_acc_cnt;
        end

        if (accept && limit_hit) begin
            r_o_x      <= '0;
            r_o_y      <= '0;
            r_o_z      <= '0;
            r_o_index  <= '0;
            r_o_comp   <= '0;
            r_o_count  <= '0;
            r_o_failed <= 1'b1;
        end else if (sel_done) begin
            r_o_x      <= SITE_W'(n_cx);
            r_o_y      <= SITE_W'(n_cy);
            r_o_z      <= SITE_W'(n_cz);
            r_o_index  <= INDEX_W'(n_cpos);
            r_o_comp   <= r_comp;
            r_o_count  <= COUNT_W'(r_cand);
            r_o_failed <= 1'b0;
        end
    end

    assign i_item.ready              = in_ready;
    assign o_result.valid            = r_ovalid;
    assign o_result.site_x           = r_o_x;
    assign o_result.site_y           = r_o_y;
    assign o_result.site_z           = r_o_z;
    assign o_result.site_index       = r_o_index;
    assign o_result.placed_component = r_o_comp;
    assign o_result.candidate_count  = r_o_count;
    assign o_result.failed           = r_o_failed;

endmodule

`default_nettype wire

@@ hdl/lfsp_checker.sv @@
// ----------------------------------------------------------------------------
// lfsp_checker
// Port level checks on the result channel of the lattice site placer.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [lfsp_pkg::SITE_W-1:0]   i_site_x,
    input wire logic [lfsp_pkg::SITE_W-1:0]   i_site_y,
    input wire logic [lfsp_pkg::SITE_W-1:0]   i_site_z,
    input wire logic [lfsp_pkg::INDEX_W-1:0]  i_site_index,
    input wire logic [lfsp_pkg::COMP_W-1:0]   i_placed_component,
    input wire logic [lfsp_pkg::COUNT_W-1:0]  i_candidate_count,
    input wire logic                          i_failed
);
    import lfsp_pkg::*;

    // a stalled result beat keeps its site index, failure flag and candidate count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_site_index) && $stable(i_failed) &&
            $stable(i_candidate_count))
        else $error("result beat changed while stalled");

    // a failure reports nothing else
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_failed |->
            i_site_x == '0 && i_site_y == '0 && i_site_z == '0 &&
            i_site_index == '0 && i_placed_component == '0 &&
            i_candidate_count == '0)
        else $error("failed beat with nonzero fields");

    // some point always holds the largest minimum
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_failed |-> i_candidate_count != '0)
        else $error("placement with zero candidates");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind lattice_farthest_site_placer_unit lfsp_checker u_lfsp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_site_x           (o_result.site_x),
    .i_site_y           (o_result.site_y),
    .i_site_z           (o_result.site_z),
    .i_site_index       (o_result.site_index),
    .i_placed_component (o_result.placed_component),
    .i_candidate_count  (o_result.candidate_count),
    .i_failed           (o_result.failed)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for lattice_farthest_site_placer_unit. A behavioral model of the
// periodic lattice keeps the minimum squared distances and the placement count
// and predicts each result beat. Directed tests cover reset defaults, the
// largest side, side clamping, the placement limit, the clear on a side write
// and output backpressure. Random phases then vary side and limit. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import lfsp_pkg::*;

    localparam int LATTICE_MAX   = 16;
    localparam int LATTICE_CELLS = LATTICE_MAX * LATTICE_MAX * LATTICE_MAX;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic [SITE_W-1:0]  site_x;
        logic [SITE_W-1:0]  site_y;
        logic [SITE_W-1:0]  site_z;
        logic [INDEX_W-1:0] site_index;
        logic [COMP_W-1:0]  placed_component;
        logic [COUNT_W-1:0] candidate_count;
        logic               failed;
    } t_placement;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_wdata;

    lfsp_in_if  item_if ();
    lfsp_out_if result_if ();

    lattice_farthest_site_placer_unit #(
        .MAX_SIDE (LATTICE_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // lattice model state
    logic [COUNT_W-1:0] lattice_min_sq [0:LATTICE_CELLS-1];
    logic [GRID_W-1:0]  grid_setting;
    int unsigned        place_limit;
    int unsigned        sites_placed;

    t_placement placements_due[$];

    int unsigned errors;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned sites_seen;
    int unsigned failures_seen;
    int unsigned cfg_writes;
    int unsigned burst_left;
    bit          steady_offer;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned sink_mode;
    int unsigned sink_mode_left;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, placements_due.size());
            $display("FAIL lattice_farthest_site_placer_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // lattice model
    // ------------------------------------------------------------------------
    function automatic int unsigned side_in_use();
        if (grid_setting < MIN_SIDE) return MIN_SIDE;
        if (grid_setting > LATTICE_MAX) return LATTICE_MAX;
        return grid_setting;
    endfunction

    function automatic void clear_lattice();
        int unsigned n;
        n = side_in_use();
        for (int p = 0; p < LATTICE_CELLS; p++)
            lattice_min_sq[p] = COUNT_W'(n * n * n);
        sites_placed = 0;
    endfunction

    // minimum image along one axis
    function automatic int unsigned wrap_gap(input int unsigned a, b, n);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        if (2 * d > n) d = n - d;
        return d;
    endfunction

    function automatic t_placement place_farthest_site(input logic start,
                                                       input logic [COMP_W-1:0] comp,
                                                       input logic [FRAC_W-1:0] frac);
        t_placement  r;
        int unsigned n, cells, best, hits, pick, seen, chosen;
        int unsigned cx, cy, cz, dx, dy, dz, d2;
        r = '0;
        if (start) clear_lattice();
        if (sites_placed >= place_limit) begin
            r.failed = 1'b1;
            return r;
        end
        n = side_in_use();
        cells = n * n * n;
        best = 0;
        hits = 0;
        for (int p = 0; p < cells; p++) begin
            if (hits == 0 || lattice_min_sq[p] > best) begin
                best = lattice_min_sq[p];
                hits = 1;
            end else if (lattice_min_sq[p] == best) begin
                hits++;
            end
        end
        pick = (int'(frac) * hits) >> 16;
        chosen = 0;
        seen = 0;
        for (int p = 0; p < cells; p++) begin
            if (lattice_min_sq[p] == best) begin
                if (seen == pick) begin
                    chosen = p;
                    break;
                end
                seen++;
            end
        end
        cz = chosen % n;
        cy = (chosen / n) % n;
        cx = chosen / (n * n);
        for (int p = 0; p < cells; p++) begin
            dx = wrap_gap(p / (n * n), cx, n);
            dy = wrap_gap((p / n) % n, cy, n);
            dz = wrap_gap(p % n, cz, n);
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < lattice_min_sq[p]) lattice_min_sq[p] = COUNT_W'(d2);
        end
        sites_placed = (sites_placed + 1) & 32'h1fff;
        r.site_x           = SITE_W'(cx);
        r.site_y           = SITE_W'(cy);
        r.site_z           = SITE_W'(cz);
        r.site_index       = INDEX_W'(chosen);
        r.placed_component = comp;
        r.candidate_count  = COUNT_W'(hits);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_GRID_SIZE) begin
            grid_setting = data[GRID_W-1:0];
            clear_lattice();
        end else begin
            place_limit = data;
        end
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic start, input logic [COMP_W-1:0] comp,
                             input logic [FRAC_W-1:0] frac);
        int unsigned gap, busy;
        if (burst_left == 0 && !steady_offer) begin
            busy = 2 * side_in_use() ** 3 + 20;
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, (busy > 1000) ? 1000 : busy);
            else
                gap = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 10);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        item_if.valid           <= 1'b1;
        item_if.start_new       <= start;
        item_if.place_component <= comp;
        item_if.random_fraction <= frac;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        placements_due.push_back(place_farthest_site(start, comp, frac));
        items_sent++;
    endtask

    // drain all results, then let the update scan finish
    task automatic quiesce();
        item_if.valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (2 * side_in_use() ** 3 + 16) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result sink: stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_stall
        logic rdy;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (sink_mode_left == 0) begin
            sink_mode      = $urandom_range(0, 3);
            sink_mode_left = $urandom_range(20, 300);
        end else begin
            sink_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (sink_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (sink_mode_left % 5 == 0);
            endcase
        end
        result_if.ready <= rdy;
    end

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_placement want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (placements_due.size() == 0) begin
                errors++;
                $display("%0t result beat with no request pending", $time);
            end else begin
                want = placements_due.pop_front();
                check_field("site_x", want.site_x, result_if.site_x);
                check_field("site_y", want.site_y, result_if.site_y);
                check_field("site_z", want.site_z, result_if.site_z);
                check_field("site_index", want.site_index, result_if.site_index);
                check_field("placed_component", want.placed_component,
                            result_if.placed_component);
                check_field("candidate_count", want.candidate_count,
                            result_if.candidate_count);
                check_field("failed", want.failed, result_if.failed);
                if (want.failed) failures_seen++;
                else sites_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // side 4, limit 4096 straight out of reset
        send_item(1'b0, 8'h00, 16'h0000);
        send_item(1'b0, 8'hff, 16'hffff);
        send_item(1'b1, 8'ha5, 16'h8000);
    endtask

    task automatic test_largest_side();
        quiesce();
        write_reg(CFG_GRID_SIZE, CFG_W'(16));
        send_item(1'b0, 8'h00, 16'hffff);
        send_item(1'b0, 8'h3c, 16'h0000);
        quiesce();
        // above the largest side clamps to it
        write_reg(CFG_GRID_SIZE, CFG_W'(31));
        send_item(1'b1, 8'hc3, 16'h0001);
    endtask

    task automatic test_side_clamp();
        quiesce();
        write_reg(CFG_GRID_SIZE, CFG_W'(0));
        send_item(1'b0, 8'h01, 16'h8000);
        quiesce();
        write_reg(CFG_GRID_SIZE, CFG_W'(2));
        send_item(1'b1, 8'h80, 16'h4000);
    endtask

    task automatic test_placement_limit();
        quiesce();
        write_reg(CFG_MAX_PLACEMENTS, CFG_W'(1));
        send_item(1'b0, 8'h11, 16'h2000);
        send_item(1'b0, 8'h22, 16'h3000);
        // start clears the count, so this one places
        send_item(1'b1, 8'h33, 16'h7fff);
        send_item(1'b0, 8'h44, 16'hc000);
        quiesce();
        // a zero limit always fails
        write_reg(CFG_MAX_PLACEMENTS, CFG_W'(0));
        send_item(1'b1, 8'h55, 16'h5555);
        quiesce();
        write_reg(CFG_MAX_PLACEMENTS, 13'h1fff);
    endtask

    task automatic test_side_write_clears();
        quiesce();
        write_reg(CFG_GRID_SIZE, CFG_W'(5));
        send_item(1'b0, 8'h5a, 16'h1234);
        send_item(1'b0, 8'h96, 16'hfedc);
        quiesce();
        // rewriting the same side still resets every minimum
        write_reg(CFG_GRID_SIZE, CFG_W'(5));
        send_item(1'b0, 8'h69, 16'h0000);
    endtask

    task automatic test_output_backpressure();
        quiesce();
        write_reg(CFG_GRID_SIZE, CFG_W'(3));
        hold_req     = 1'b1;
        steady_offer = 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(i == 0, COMP_W'($urandom()), FRAC_W'($urandom()));
        steady_offer = 1'b0;
    endtask

    task automatic test_random_phases();
        int unsigned grid, lim, n_items;
        for (int phase = 0; phase < 9; phase++) begin
            quiesce();
            if (phase == 4) grid = $urandom_range(17, 31);
            else if (phase == 7) grid = $urandom_range(0, 2);
            else grid = $urandom_range(3, 7);
            write_reg(CFG_GRID_SIZE, CFG_W'(grid));
            if (phase % 3 == 2) lim = $urandom_range(1, 6);
            else if (phase == 5) lim = 13'h1fff;
            else lim = $urandom_range(7, 8191);
            write_reg(CFG_MAX_PLACEMENTS, CFG_W'(lim));
            n_items = (side_in_use() == LATTICE_MAX) ? 2 : 10;
            for (int i = 0; i < n_items; i++)
                send_item($urandom_range(0, 7) == 0, COMP_W'($urandom()),
                          FRAC_W'($urandom()));
        end
    endtask

    initial begin
        i_clk                     = 1'b0;
        i_rst_n                   = 1'b0;
        cfg_we                    = 1'b0;
        cfg_idx                   = CFG_GRID_SIZE;
        cfg_wdata                 = '0;
        item_if.valid             = 1'b0;
        item_if.start_new         = 1'b0;
        item_if.place_component   = '0;
        item_if.random_fraction   = '0;
        result_if.ready           = 1'b0;
        grid_setting              = GRID_W'(RESET_GRID_SIZE);
        place_limit               = RESET_MAX_PLACEMENTS;
        clear_lattice();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_largest_side();
        test_side_clamp();
        test_placement_limit();
        test_side_write_clears();
        test_output_backpressure();
        test_random_phases();
        quiesce();

        $display("run covered %0d requests: %0d sites placed, %0d limit failures",
                 items_sent, sites_seen, failures_seen);
        $display("%0d register writes, sides from clamped low to clamped high, %0d cycles",
                 cfg_writes, cycle_count);
        if (errors == 0 && placements_due.size() == 0) begin
            $display("PASS lattice_farthest_site_placer_unit");
        end else begin
            $display("FAIL lattice_farthest_site_placer_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lfsp_pkg.sv
hdl/lfsp_in_if.sv
hdl/lfsp_out_if.sv
hdl/lfsp_grid_mem.sv
hdl/lfsp_dist.sv
hdl/lattice_farthest_site_placer_unit.sv
hdl/lfsp_checker.sv
sim/tb.sv
